>>> design/io_port_permission_bitmap_top_macros.svh
// Assertion macros shared by the permission bitmap RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef IO_PORT_PERMISSION_BITMAP_TOP_MACROS_SVH
`define IO_PORT_PERMISSION_BITMAP_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define IOPB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IOPB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IOPB_ASSERT(label, clk, rst, prop, msg)
`define IOPB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> design/iopb_pkg.sv
// Types and constants for the I/O port permission bitmap.
// Used by every module of the block; depends on nothing.
package iopb_pkg;

  localparam int PORT_SPACE = 65536;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = (PORT_SPACE + WORD_BITS - 1) / WORD_BITS;
  localparam int PORT_W     = 16;
  localparam int CNT_W      = 16;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int END_W      = PORT_W + 1;

  localparam logic [BIT_W-1:0]  TOP_BIT     = BIT_W'(WORD_BITS - 1);
  localparam logic [END_W-1:0]  SPACE_END   = END_W'(PORT_SPACE);
  localparam logic [ADDR_W-1:0] LAST_WORD   = ADDR_W'(WORD_COUNT - 1);

  typedef enum logic [1:0] {
    REQ_GRANT  = 2'd0,
    REQ_REVOKE = 2'd1,
    REQ_CHECK  = 2'd2,
    REQ_RANGE  = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
  } iopb_mem_req_t;

  // inclusive bit span within one word
  typedef struct packed {
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } iopb_span_t;

endpackage

>>> design/iopb_mem.sv
// Bitmap word store: one write port, one registered read port.
// Uses iopb_pkg for widths and the request struct.
module iopb_mem
  import iopb_pkg::*;
(
  input  logic                 clk,
  input  iopb_mem_req_t        req,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [WORD_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

>>> design/iopb_mask.sv
// Shared mask unit: builds the word mask for an inclusive bit span.
// Uses iopb_pkg for the span type and word width.
module iopb_mask
  import iopb_pkg::*;
(
  input  iopb_span_t           span,
  output logic [WORD_BITS-1:0] mask
);

  logic [WORD_BITS-1:0] lo_part;
  logic [WORD_BITS-1:0] hi_part;

  always_comb begin
    lo_part = {WORD_BITS{1'b1}} << span.lo;
    hi_part = {WORD_BITS{1'b1}} >> (TOP_BIT - span.hi);
    mask    = lo_part & hi_part;
  end

endmodule

>>> design/iopb_ctrl.sv
// Sequencer: clears the bitmap after reset, then walks each request word by word.
// Uses iopb_pkg and the assertion macros; drives iopb_mem and iopb_mask.
`include "io_port_permission_bitmap_top_macros.svh"
module iopb_ctrl
  import iopb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [PORT_W-1:0]    in_port,
  input  logic [CNT_W-1:0]     in_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_allowed,
  output logic                 out_status,
  output iopb_mem_req_t        mem_req,
  input  logic [WORD_BITS-1:0] rdata,
  output iopb_span_t           span,
  input  logic [WORD_BITS-1:0] mask
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_DONE
  } state_t;

  state_t            state;
  req_kind_t         kind;
  logic [BIT_W-1:0]  lo_bit;
  logic [BIT_W-1:0]  hi_bit;
  logic [ADDR_W-1:0] first_w;
  logic [ADDR_W-1:0] last_w;
  logic [ADDR_W-1:0] cur_w;
  logic              allowed_r;
  logic              status_r;

  logic [END_W-1:0]  end_sum;
  logic [END_W-1:0]  end_clip;
  logic [END_W-1:0]  end_m1;
  logic              empty;
  logic              accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    end_sum  = END_W'(in_port) + END_W'(in_count);
    end_clip = (end_sum > SPACE_END) ? SPACE_END : end_sum;
    empty    = (end_clip <= END_W'(in_port));
    end_m1   = end_clip - END_W'(1);
  end

  always_comb begin
    span.lo = (cur_w == first_w) ? lo_bit : '0;
    span.hi = (cur_w == last_w) ? hi_bit : TOP_BIT;
  end

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = cur_w;
    mem_req.wdata = '0;
    mem_req.re    = (state == ST_RD);
    mem_req.raddr = cur_w;
    case (state)
      ST_CLEAR: mem_req.we = 1'b1;
      ST_CHK: begin
        if (kind == REQ_GRANT) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = rdata | mask;
        end else if (kind == REQ_REVOKE) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = rdata & ~mask;
        end
      end
      default: mem_req.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cur_w     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          cur_w <= cur_w + ADDR_W'(1);
          if (cur_w == LAST_WORD) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            kind      <= req_kind_t'(in_kind);
            lo_bit    <= in_port[BIT_W-1:0];
            hi_bit    <= end_m1[BIT_W-1:0];
            first_w   <= in_port[PORT_W-1:BIT_W];
            cur_w     <= in_port[PORT_W-1:BIT_W];
            allowed_r <= 1'b0;
            status_r  <= 1'b0;
            if (req_kind_t'(in_kind) == REQ_CHECK) begin
              last_w <= in_port[PORT_W-1:BIT_W];
              state  <= ST_RD;
            end else begin
              last_w <= end_m1[PORT_W-1:BIT_W];
              // an empty range touches nothing and succeeds
              state  <= empty ? ST_DONE : ST_RD;
            end
          end
        end
        ST_RD: state <= ST_CHK;
        ST_CHK: begin
          if (kind == REQ_CHECK) begin
            allowed_r <= rdata[lo_bit];
            state     <= ST_DONE;
          end else if (kind == REQ_RANGE && ((rdata & mask) != mask)) begin
            status_r <= 1'b1;
            state    <= ST_DONE;
          end else if (cur_w == last_w) begin
            state <= ST_DONE;
          end else begin
            cur_w <= cur_w + ADDR_W'(1);
            state <= ST_RD;
          end
        end
        ST_DONE: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            out_allowed <= allowed_r;
            out_status  <= status_r;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `IOPB_ASSERT(a_chk_after_rd, clk, rst, (state == ST_CHK) |-> ($past(state) == ST_RD), "word compare without a read")
  `IOPB_ASSERT(a_walk_bound, clk, rst, (state == ST_RD) |-> (cur_w <= last_w), "word walk past last word")
  `IOPB_ASSERT(a_write_owner, clk, rst, mem_req.we |-> (state == ST_CLEAR || state == ST_CHK), "bitmap write outside clear or update")
  `IOPB_ASSERT(a_one_flag, clk, rst, out_valid |-> !(out_allowed && out_status), "allowed and denied both set")

endmodule

>>> design/io_port_permission_bitmap_top.sv
// Top level of the I/O port permission bitmap.
// Depends on iopb_pkg, iopb_mem, iopb_mask and iopb_ctrl.
//
//  channel   | direction | tdata                          | tuser
//  s_axis    | in        | [15:0] port, [31:16] count     | [1:0] req_type
//  m_axis    | out       | [0] allowed, [1] status        | -
//
// After reset the bitmap is cleared one word per cycle, all 2048 words, with s_axis_tready low.
// A check reads its one word and returns the addressed bit; a range op walks the words it
// touches, with one registered read and one update or compare of the word memory per word.
// An empty range touches no word. A denied range request stops at the first word
// with a missing bit.
// The next beat is taken while a result still waits on m_axis_tready.
module io_port_permission_bitmap_top
  import iopb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] port, [31:16] count
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] allowed, [1] status, [7:2] zero
);

  iopb_mem_req_t        mem_req;
  logic [WORD_BITS-1:0] rdata;
  iopb_span_t           span;
  logic [WORD_BITS-1:0] mask;
  logic                 allowed;
  logic                 status;

  iopb_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  iopb_mask u_mask (
    .span (span),
    .mask (mask)
  );

  iopb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_kind     (s_axis_tuser),
    .in_port     (s_axis_tdata[PORT_W-1:0]),
    .in_count    (s_axis_tdata[PORT_W+CNT_W-1:PORT_W]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_allowed (allowed),
    .out_status  (status),
    .mem_req     (mem_req),
    .rdata       (rdata),
    .span        (span),
    .mask        (mask)
  );

  assign m_axis_tdata = {6'b0, status, allowed};

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for io_port_permission_bitmap_top.
// Keeps its own copy of the permission bitmap, streams grant, revoke, check and
// range requests at it and compares every result beat in order; needs iopb_pkg.
module tb;
  import iopb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 500;
  localparam int unsigned TAIL_CYCLES    = 100;

  typedef struct packed {
    logic status;
    logic allowed;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] port, [31:16] count
  logic [1:0]  s_axis_tuser;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;   // [0] allowed, [1] status, [7:2] zero

  logic [WORD_BITS-1:0] perm_words [WORD_COUNT];
  reply_t               expected_replies [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned beats_sent     = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  io_port_permission_bitmap_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one request to the local bitmap and work out its result.
  function automatic void predict_reply(input req_kind_t kind, input logic [15:0] port,
                                        input logic [15:0] count, output reply_t reply);
    int unsigned stop_port;
    int unsigned p;
    stop_port = int'(port) + int'(count);
    if (stop_port > PORT_SPACE) stop_port = PORT_SPACE;
    reply = '0;
    case (kind)
      REQ_GRANT: begin
        for (p = port; p < stop_port; p++) perm_words[p / WORD_BITS][p % WORD_BITS] = 1'b1;
      end
      REQ_REVOKE: begin
        for (p = port; p < stop_port; p++) perm_words[p / WORD_BITS][p % WORD_BITS] = 1'b0;
      end
      REQ_CHECK: begin
        if (port < PORT_SPACE) reply.allowed = perm_words[port / WORD_BITS][port % WORD_BITS];
      end
      default: begin
        for (p = port; p < stop_port; p++) begin
          if (!perm_words[p / WORD_BITS][p % WORD_BITS]) begin
            reply.status = 1'b1;
            break;
          end
        end
      end
    endcase
  endfunction

  function automatic void report_mismatch(input string msg);
    if (mismatches < 10) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endfunction

  task automatic send_beat(input req_kind_t kind, input logic [15:0] port,
                           input logic [15:0] count);
    reply_t reply;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {count, port};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    predict_reply(kind, port, count, reply);
    expected_replies.push_back(reply);
    beats_sent++;
  endtask

  task automatic wait_for_results;
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // Mostly short ranges; now and then an empty one or one of any length.
  function automatic logic [15:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return 16'($urandom_range(65535));
    if (r < 10) return 16'd0;
    if (r < 70) return 16'($urandom_range(40, 1));
    return 16'($urandom_range(300, 41));
  endfunction

  // Crowd ports into a low window so grants and requests overlap; some run past the end.
  function automatic logic [15:0] pick_port(input int unsigned span);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 16'($urandom_range(2047));
    if (r < 80) return 16'(PORT_SPACE - 1 - $urandom_range(span));
    return 16'($urandom_range(65535));
  endfunction

  // Grant a range, then probe and punch holes in it.
  task automatic send_grant_sequence;
    logic [15:0] base;
    logic [15:0] n;
    logic [15:0] off;
    logic [15:0] sub;
    n    = pick_count();
    base = pick_port(n);
    send_beat(REQ_GRANT, base, n);
    repeat ($urandom_range(5, 1)) begin
      off = (n == 0) ? 16'd0 : 16'($urandom_range(n - 1));
      sub = 16'($urandom_range(n - off));
      case ($urandom_range(4))
        0: send_beat(REQ_RANGE, base + off, sub);
        1: send_beat(REQ_CHECK, base + off, 16'($urandom));
        2: send_beat(REQ_CHECK, base + n, 16'($urandom));
        3: send_beat(REQ_REVOKE, base + off, 16'($urandom_range(2)));
        default: send_beat(REQ_RANGE, base - 16'd1, n + 16'd2);
      endcase
    end
  endtask

  task automatic test_directed_cases;
    // fresh bitmap: nothing allowed, empty range still succeeds
    send_beat(REQ_CHECK, 16'd0, 16'd0);
    send_beat(REQ_CHECK, 16'hFFFF, 16'hFFFF);
    send_beat(REQ_RANGE, 16'd0, 16'd0);
    send_beat(REQ_RANGE, 16'd0, 16'd1);
    send_beat(REQ_GRANT, 16'd0, 16'd0);
    send_beat(REQ_CHECK, 16'd0, 16'd0);
    // ranges clipped at the top of the port space
    send_beat(REQ_GRANT, 16'd65530, 16'hFFFF);
    send_beat(REQ_CHECK, 16'hFFFF, 16'd0);
    send_beat(REQ_RANGE, 16'd65530, 16'd100);
    send_beat(REQ_RANGE, 16'd65529, 16'd2);
    // range across a word boundary, then a hole in it
    send_beat(REQ_GRANT, 16'd100, 16'd64);
    send_beat(REQ_RANGE, 16'd100, 16'd64);
    send_beat(REQ_RANGE, 16'd99, 16'd2);
    send_beat(REQ_CHECK, 16'd163, 16'd0);
    send_beat(REQ_CHECK, 16'd164, 16'd0);
    send_beat(REQ_REVOKE, 16'd120, 16'd1);
    send_beat(REQ_RANGE, 16'd100, 16'd64);
    send_beat(REQ_CHECK, 16'd121, 16'd0);
    // all of the port space below the top port, then the top port alone
    send_beat(REQ_GRANT, 16'd0, 16'hFFFF);
    send_beat(REQ_RANGE, 16'd0, 16'hFFFF);
    send_beat(REQ_REVOKE, 16'd0, 16'hFFFF);
    send_beat(REQ_CHECK, 16'hFFFF, 16'd1);
    send_beat(REQ_REVOKE, 16'hFFFF, 16'hFFFF);
    send_beat(REQ_CHECK, 16'hFFFF, 16'd0);
    send_beat(REQ_RANGE, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned target;
    target = beats_sent + n_items;
    while (beats_sent < target) begin
      if ($urandom_range(99) < 75) send_grant_sequence();
      else send_beat(req_kind_t'($urandom_range(3)), 16'($urandom), pick_count());
    end
  endtask

  // Hold the result side off while beats keep coming, so the block backs up.
  task automatic test_output_stall;
    hold_requests++;
    repeat (40) send_beat(req_kind_t'($urandom_range(3)), 16'($urandom_range(511)),
                          16'($urandom_range(40)));
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_GRANT;
    foreach (perm_words[w]) perm_words[w] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    wait_for_results();

    send_idle_pct  = 28;
    recv_stall_pct = 82;
    test_random_traffic(400);
    wait_for_results();

    send_idle_pct  = 82;
    recv_stall_pct = 28;
    test_random_traffic(400);
    wait_for_results();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_output_stall();
    test_random_traffic(400);
    wait_for_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served   <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat tdata=%02h", m_axis_tdata));
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tdata[0] !== want.allowed || m_axis_tdata[1] !== want.status ||
            m_axis_tdata[7:2] !== 6'd0)
          report_mismatch($sformatf("expected allowed=%0b status=%0b, got tdata=%02h",
                                    want.allowed, want.status, m_axis_tdata));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
